### hw/rtl/dtq_pkg.sv
// dtq_pkg: shared types and codes for the two-class work queue
// no dependencies
`timescale 1ns / 1ps
package dtq_pkg;

	localparam int KEY_W = 64;

	typedef enum logic [1:0] {
		CLS_FREE   = 2'd0,
		CLS_NORMAL = 2'd1,
		CLS_URGENT = 2'd2
	} cls_t;

	typedef enum logic [2:0] {
		ST_NEW      = 3'd0,
		ST_PROMOTED = 3'd1,
		ST_ALREADY  = 3'd2,
		ST_NO_ROOM  = 3'd3,
		ST_DEQUEUED = 3'd4,
		ST_EMPTY    = 3'd5
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_WAIT,
		S_DECIDE,
		S_POP,
		S_POP_SCAN,
		S_POP_SCAN_WAIT,
		S_POP_CHECK,
		S_DONE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic load;        // capture request
		logic scan_start;  // clear scan state, start table sweep with req key
		logic scan_step;   // look at next table entry
		logic apply_enq;   // perform enqueue decision
		logic pop_issue;   // read fifo head, advance head
		logic pop_key_scan; // start sweep with popped key
		logic serve_cur;   // free matched slot, publish dequeue
		logic set_empty;   // publish empty
		logic pick_urgent; // which fifo to pop
	} dtq_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_deq;
		logic scan_done;
		logic match_ok;    // popped key held in matching class
		logic urg_nonempty;
		logic nrm_nonempty;
	} dtq_stat_t;

endpackage

### hw/rtl/dtq_if.sv
// dtq_if: valid/ready channel interfaces for requests and responses
// no dependencies
`timescale 1ns / 1ps
interface dtq_req_if;
	logic        valid;
	logic        ready;
	logic        command;
	logic        urgent;
	logic [63:0] item_key;
	modport source (output valid, command, urgent, item_key, input ready);
	modport sink (input valid, command, urgent, item_key, output ready);
endinterface

interface dtq_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [63:0] out_key;
	logic        served_urgent;
	modport source (output valid, status, out_key, served_urgent, input ready);
	modport sink (input valid, status, out_key, served_urgent, output ready);
endinterface

### hw/rtl/dtq_ram.sv
// dtq_ram: generic single write, single read ram with registered read
// no dependencies
`timescale 1ns / 1ps
module dtq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/dtq_datapath.sv
// dtq_datapath: membership table, two key fifos and the table sweep
// depends on dtq_pkg and dtq_ram
`timescale 1ns / 1ps
module dtq_datapath
	import dtq_pkg::*;
#(
	parameter int TRACKED_KEYS = 64,
	parameter int FIFO_DEPTH   = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dtq_cmd_t    cmd,
	output dtq_stat_t   stat,
	input  logic        in_command,
	input  logic        in_urgent,
	input  logic [63:0] in_key,
	output logic [2:0]  res_status,
	output logic [63:0] res_key,
	output logic        res_urgent
);
	localparam int TW = $clog2(TRACKED_KEYS);
	localparam int FW = $clog2(FIFO_DEPTH);
	localparam int CW = $clog2(FIFO_DEPTH + 1);
	localparam int SW = $clog2(TRACKED_KEYS + 1);

	// class table in flops, keys in ram
	cls_t             cls_q [TRACKED_KEYS];
	logic             cmd_q, urg_q;
	logic [63:0]      key_q;
	logic [SW-1:0]    sidx_q;
	logic [TW-1:0]    ridx_q;
	logic             rpend_q;
	logic             hit_q, free_found_q;
	logic [TW-1:0]    hit_idx_q, free_idx_q;
	logic [FW-1:0]    uhead_q, nhead_q;
	logic [CW-1:0]    ucnt_q, ncnt_q;
	logic             pop_urg_q;
	logic [63:0]      tab_rdata, ufifo_rdata, nfifo_rdata;
	logic             tab_we, ufifo_we, nfifo_we;
	logic [FW-1:0]    utail, ntail;
	logic             ufull, nfull;
	logic             match_now;

	// tail position, no wrap beyond depth since count never exceeds it
	function automatic logic [FW-1:0] tail_of(logic [FW-1:0] h, logic [CW-1:0] c);
		logic [CW:0] s;
		s = {1'b0, c} + CW'(h) + (CW+1)'(0);
		if (s >= (CW+1)'(FIFO_DEPTH)) begin
			s = s - (CW+1)'(FIFO_DEPTH);
		end
		return s[FW-1:0];
	endfunction

	function automatic logic [FW-1:0] inc_of(logic [FW-1:0] h);
		return (h == FW'(FIFO_DEPTH - 1)) ? '0 : h + FW'(1);
	endfunction

	assign utail = tail_of(uhead_q, ucnt_q);
	assign ntail = tail_of(nhead_q, ncnt_q);
	assign ufull = (ucnt_q == CW'(FIFO_DEPTH));
	assign nfull = (ncnt_q == CW'(FIFO_DEPTH));
	assign match_now = rpend_q && (cls_q[ridx_q] != CLS_FREE) && (tab_rdata == key_q);

	// write enables for the enqueue decision
	logic promote, add_new;
	always_comb begin
		promote = 1'b0;
		add_new = 1'b0;
		if (cmd.apply_enq) begin
			if (hit_q) begin
				promote = urg_q && (cls_q[hit_idx_q] == CLS_NORMAL) && !ufull;
			end else begin
				add_new = free_found_q && !(urg_q ? ufull : nfull);
			end
		end
	end
	assign tab_we   = add_new;
	assign ufifo_we = promote || (add_new && urg_q);
	assign nfifo_we = add_new && !urg_q;

	dtq_ram #(.WIDTH(64), .DEPTH(TRACKED_KEYS)) u_tab (
		.clk(clk), .we(tab_we), .waddr(free_idx_q), .wdata(key_q),
		.raddr(sidx_q[TW-1:0]), .rdata(tab_rdata)
	);
	dtq_ram #(.WIDTH(64), .DEPTH(FIFO_DEPTH)) u_ufifo (
		.clk(clk), .we(ufifo_we), .waddr(utail), .wdata(key_q),
		.raddr(uhead_q), .rdata(ufifo_rdata)
	);
	dtq_ram #(.WIDTH(64), .DEPTH(FIFO_DEPTH)) u_nfifo (
		.clk(clk), .we(nfifo_we), .waddr(ntail), .wdata(key_q),
		.raddr(nhead_q), .rdata(nfifo_rdata)
	);

	assign stat.is_deq       = cmd_q;
	assign stat.scan_done    = (sidx_q == SW'(TRACKED_KEYS)) && !rpend_q;
	assign stat.match_ok     = hit_q && (cls_q[hit_idx_q] == (pop_urg_q ? CLS_URGENT : CLS_NORMAL));
	assign stat.urg_nonempty = (ucnt_q != '0);
	assign stat.nrm_nonempty = (ncnt_q != '0);

	// control registers: sweep, fifo pointers, class table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TRACKED_KEYS; i++) cls_q[i] <= CLS_FREE;
			sidx_q <= '0; rpend_q <= 1'b0; hit_q <= 1'b0; free_found_q <= 1'b0;
			uhead_q <= '0; nhead_q <= '0; ucnt_q <= '0; ncnt_q <= '0;
			pop_urg_q <= 1'b0; cmd_q <= 1'b0; urg_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cmd_q <= in_command;
				urg_q <= in_urgent;
			end
			if (cmd.scan_start || cmd.pop_key_scan) begin
				sidx_q <= '0; rpend_q <= 1'b0; hit_q <= 1'b0; free_found_q <= 1'b0;
			end else if (cmd.scan_step) begin
				// one entry per cycle; ram read lands next cycle
				if (match_now && !hit_q) begin
					hit_q <= 1'b1;
				end
				if (rpend_q && !free_found_q && cls_q[ridx_q] == CLS_FREE) begin
					free_found_q <= 1'b1;
				end
				if (sidx_q != SW'(TRACKED_KEYS)) begin
					rpend_q <= 1'b1;
					sidx_q <= sidx_q + SW'(1);
				end else begin
					rpend_q <= 1'b0;
				end
			end
			if (cmd.pop_issue) begin
				pop_urg_q <= cmd.pick_urgent;
				if (cmd.pick_urgent) begin
					uhead_q <= inc_of(uhead_q); ucnt_q <= ucnt_q - CW'(1);
				end else begin
					nhead_q <= inc_of(nhead_q); ncnt_q <= ncnt_q - CW'(1);
				end
			end
			if (promote) begin
				cls_q[hit_idx_q] <= CLS_URGENT;
				ucnt_q <= ucnt_q + CW'(1);
			end
			if (add_new) begin
				cls_q[free_idx_q] <= urg_q ? CLS_URGENT : CLS_NORMAL;
				if (urg_q) ucnt_q <= ucnt_q + CW'(1);
				else ncnt_q <= ncnt_q + CW'(1);
			end
			if (cmd.serve_cur) begin
				cls_q[hit_idx_q] <= CLS_FREE;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load) key_q <= in_key;
		if (cmd.pop_key_scan) key_q <= pop_urg_q ? ufifo_rdata : nfifo_rdata;
		if (cmd.scan_step) begin
			ridx_q <= sidx_q[TW-1:0];
			if (match_now && !hit_q) hit_idx_q <= ridx_q;
			if (rpend_q && !free_found_q && cls_q[ridx_q] == CLS_FREE) free_idx_q <= ridx_q;
		end
		if (cmd.apply_enq) begin
			res_key <= '0; res_urgent <= 1'b0;
			if (hit_q) begin
				if (urg_q && cls_q[hit_idx_q] == CLS_NORMAL)
					res_status <= ufull ? ST_NO_ROOM : ST_PROMOTED;
				else
					res_status <= ST_ALREADY;
			end else begin
				res_status <= add_new ? ST_NEW : ST_NO_ROOM;
			end
		end
		if (cmd.serve_cur) begin
			res_status <= ST_DEQUEUED; res_key <= key_q; res_urgent <= pop_urg_q;
		end
		if (cmd.set_empty) begin
			res_status <= ST_EMPTY; res_key <= '0; res_urgent <= 1'b0;
		end
	end

	// counts stay within depth, and no pop is issued from an empty fifo
	assert property (@(posedge clk) disable iff (!arst_n) ucnt_q <= CW'(FIFO_DEPTH))
		else $error("urgent count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) ncnt_q <= CW'(FIFO_DEPTH))
		else $error("normal count overflow");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.pop_issue && cmd.pick_urgent
		|-> ucnt_q != '0) else $error("pop from empty urgent fifo");
	assert property (@(posedge clk) disable iff (!arst_n) cmd.pop_issue && !cmd.pick_urgent
		|-> ncnt_q != '0) else $error("pop from empty normal fifo");
endmodule

### hw/rtl/dtq_ctrl.sv
// dtq_ctrl: request sequencer for enqueue and dequeue
// depends on dtq_pkg
`timescale 1ns / 1ps
module dtq_ctrl
	import dtq_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  dtq_stat_t stat,
	output dtq_cmd_t  cmd
);
	state_t state_q, state_d;
	logic   res_full_q;
	logic   publish;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:   if (in_valid && !res_full_q) state_d = S_SCAN;
			S_SCAN:   state_d = stat.is_deq ? S_POP : S_SCAN_WAIT;
			S_SCAN_WAIT: if (stat.scan_done) state_d = S_DECIDE;
			S_DECIDE: state_d = S_DONE;
			S_POP: begin
				// head word lands in the ram read register on the next cycle
				if (stat.urg_nonempty || stat.nrm_nonempty) state_d = S_POP_SCAN;
				else state_d = S_DONE;
			end
			S_POP_SCAN: state_d = S_POP_SCAN_WAIT;
			S_POP_SCAN_WAIT: if (stat.scan_done) state_d = S_POP_CHECK;
			S_POP_CHECK: state_d = stat.match_ok ? S_DONE : S_POP;
			S_DONE:   state_d = S_IDLE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = !res_full_q;
				cmd.load = in_valid && !res_full_q;
			end
			S_SCAN: cmd.scan_start = 1'b1;
			S_SCAN_WAIT: cmd.scan_step = 1'b1;
			S_DECIDE: cmd.apply_enq = 1'b1;
			S_POP: begin
				cmd.pick_urgent = stat.urg_nonempty;
				cmd.pop_issue = stat.urg_nonempty || stat.nrm_nonempty;
				cmd.set_empty = !(stat.urg_nonempty || stat.nrm_nonempty);
			end
			S_POP_SCAN: cmd.pop_key_scan = 1'b1;
			S_POP_SCAN_WAIT: cmd.scan_step = 1'b1;
			S_POP_CHECK: cmd.serve_cur = stat.match_ok;
			S_DONE: ;
			default: ;
		endcase
	end

	assign publish = (state_q == S_DONE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			res_full_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish) res_full_q <= 1'b1;
			else if (out_ready) res_full_q <= 1'b0;
		end
	end
	assign out_valid = res_full_q;

	assert property (@(posedge clk) disable iff (!arst_n) in_valid && in_ready
		|=> state_q == S_SCAN) else $error("accept did not start work");
	assert property (@(posedge clk) disable iff (!arst_n) publish |-> !res_full_q)
		else $error("result overwritten");
	assert property (@(posedge clk) disable iff (!arst_n) in_ready |-> state_q == S_IDLE)
		else $error("ready while busy");
endmodule

### hw/rtl/dedup_two_class_work_queue_top.sv
// dedup_two_class_work_queue_top: deduplicating two-class key work queue
// enqueue: result follows a full sweep of the key table (one table entry read per cycle)
// dequeue: pops the urgent fifo first, sweeps the table for the popped key and skips stale entries;
// reports empty when both fifos are empty
// one request in flight; next accept only after the result word is taken
// reset: async active low clears class table, fifo pointers and control; no clearing pass
`timescale 1ns / 1ps
module dedup_two_class_work_queue_top
	import dtq_pkg::*;
#(
	parameter int TRACKED_KEYS = 64,
	parameter int FIFO_DEPTH   = 128
) (
	input  logic clk,
	input  logic arst_n,
	dtq_req_if.sink   req,
	dtq_rsp_if.source rsp
);
	dtq_cmd_t  cmd;
	dtq_stat_t stat;

	dtq_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(req.valid), .in_ready(req.ready),
		.out_valid(rsp.valid), .out_ready(rsp.ready),
		.stat(stat), .cmd(cmd)
	);

	dtq_datapath #(.TRACKED_KEYS(TRACKED_KEYS), .FIFO_DEPTH(FIFO_DEPTH)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.in_command(req.command), .in_urgent(req.urgent), .in_key(req.item_key),
		.res_status(rsp.status), .res_key(rsp.out_key), .res_urgent(rsp.served_urgent)
	);
endmodule
